FILE: design/tpp_pkg.sv
// shared constants and types for the two-plane prom pixel colour core
package tpp_pkg;

  localparam int VideoBytesDefault = 16384;
  localparam int PromDepthDefault  = 256;

  localparam int OffsetW  = 14;
  localparam int ByteW    = 8;
  localparam int PaletteW = 5;
  localparam int VariantW = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  typedef logic [ByteW-1:0]    byte_t;
  typedef logic [PaletteW-1:0] palette_t;
  typedef logic [VariantW-1:0] variant_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;
  typedef logic [OffsetW-1:0]  offset_t;

  localparam cfg_idx_t RegPaletteOne = 2'd0;
  localparam cfg_idx_t RegPaletteTwo = 2'd1;
  localparam cfg_idx_t RegFlip       = 2'd2;
  localparam cfg_idx_t RegVariant    = 2'd3;

  localparam variant_t VariantFirst = 2'd0;

  localparam logic KindPixels = 1'b0;
  localparam logic KindLoad   = 1'b1;

  localparam logic PromOne = 1'b0;

endpackage

FILE: design/two_plane_prom_pixel_colour_core.sv
// two-plane prom pixel colour core: table loads and byte pair to pixel conversion
// a byte pair beat passes from the item register to stage one (table one read)
// and stage two (output); a table load writes its table on issue; the four pixels
// leave the item register, and the output, one per cycle while out_stall is low
// the two colour tables are synchronous memories read back to back
// reset clears config registers and pipeline valids; table contents stay undefined
module two_plane_prom_pixel_colour_core #(
  parameter int VIDEO_BYTES = tpp_pkg::VideoBytesDefault,
  parameter int PROM_DEPTH  = tpp_pkg::PromDepthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  tpp_pkg::offset_t   in_offset,
  input  tpp_pkg::byte_t     in_plane_one_byte,
  input  tpp_pkg::byte_t     in_plane_two_byte,
  input  logic               in_prom_select,
  input  tpp_pkg::byte_t     in_prom_address,
  input  tpp_pkg::byte_t     in_prom_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tpp_pkg::byte_t     out_pixel_x,
  output tpp_pkg::byte_t     out_pixel_y,
  output logic               out_red,
  output logic               out_green,
  output logic               out_blue,
  output logic               out_last_pixel,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  tpp_pkg::cfg_idx_t  cfg_index,
  input  tpp_pkg::cfg_data_t cfg_data
);
  import tpp_pkg::*;

  localparam logic [OffsetW:0] VideoLimit = (OffsetW+1)'(VIDEO_BYTES);

  // config registers
  palette_t palette_one_r, palette_two_r;
  logic     flip_r;
  variant_t variant_r;

  // item register
  logic       cur_valid_r, cur_kind_r, cur_sel_r;
  offset_t    cur_off_r;
  byte_t      cur_d1_r, cur_d2_r, cur_addr_r, cur_data_r;
  logic [1:0] idx_r;

  // stage one: table one data pending
  logic       s1_valid_r, s1_last_r, s1_pb_r;
  byte_t      s1_x_r, s1_y_r;
  logic [1:0] s1_code2_r;

  // stage two: output
  logic  out_valid_r, out_last_r;
  byte_t out_x_r, out_y_r, c1_r;

  byte_t mem_one [PROM_DEPTH];
  byte_t mem_two [PROM_DEPTH];
  byte_t rd1_r, rd2_r;

  logic       adv, issue, cur_done, in_ready, in_acc, in_keep;
  logic [7:0] s1_sh, s2_sh;
  logic [1:0] code1;
  byte_t      a1, a2, x_raw, y_raw;
  logic       bit7_two;
  logic [2:0] colour;

  assign cfg_ready = 1'b1;

  assign adv      = !out_valid_r || !out_stall;
  assign issue    = adv && cur_valid_r;
  assign cur_done = issue && (cur_kind_r == KindLoad || idx_r == 2'd3);
  assign in_ready = !cur_valid_r || cur_done;
  assign in_stall = !in_ready;
  assign in_acc   = in_valid && in_ready;
  assign in_keep  = (in_kind == KindLoad) || ({1'b0, in_offset} < VideoLimit);

  always_comb begin
    s1_sh = cur_d1_r >> idx_r;
    s2_sh = cur_d2_r >> idx_r;
    code1 = {s1_sh[4], s1_sh[0]};
    a1    = {(variant_r == VariantFirst) ? palette_one_r[1] : 1'b0, palette_one_r, code1};
    x_raw = {cur_off_r[5:0], idx_r};
    y_raw = cur_off_r[13:6];
    bit7_two = (variant_r == VariantFirst) ? (palette_two_r[1] | rd1_r[0] | rd1_r[1])
                                           : s1_pb_r;
    a2     = {bit7_two, palette_two_r, s1_code2_r};
    colour = c1_r[2:0] | rd2_r[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_one_r <= '0;
      palette_two_r <= '0;
      flip_r        <= 1'b0;
      variant_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegPaletteOne: palette_one_r <= cfg_data[PaletteW-1:0];
        RegPaletteTwo: palette_two_r <= cfg_data[PaletteW-1:0];
        RegFlip:       flip_r        <= cfg_data[0];
        RegVariant:    variant_r     <= cfg_data[VariantW-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cur_valid_r <= in_keep;
        idx_r       <= '0;
      end else begin
        if (cur_done) cur_valid_r <= 1'b0;
        if (issue) idx_r <= idx_r + 2'd1;
      end
      if (adv) begin
        s1_valid_r  <= issue && (cur_kind_r == KindPixels);
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_kind_r <= in_kind;
      cur_sel_r  <= in_prom_select;
      cur_off_r  <= in_offset;
      cur_d1_r   <= in_plane_one_byte;
      cur_d2_r   <= in_plane_two_byte;
      cur_addr_r <= in_prom_address;
      cur_data_r <= in_prom_data;
    end
    if (adv) begin
      s1_x_r     <= flip_r ? ~x_raw : x_raw;
      s1_y_r     <= flip_r ? ~y_raw : y_raw;
      s1_last_r  <= (idx_r == 2'd3);
      s1_pb_r    <= s1_sh[4] | s1_sh[0];
      s1_code2_r <= {s2_sh[4], s2_sh[0]};
      out_x_r    <= s1_x_r;
      out_y_r    <= s1_y_r;
      out_last_r <= s1_last_r;
      c1_r       <= rd1_r;
    end
  end

  // table one: read for the issuing pixel, write on a load beat
  always_ff @(posedge clk) begin
    if (adv) begin
      rd1_r <= mem_one[a1];
      if (issue && cur_kind_r == KindLoad && cur_sel_r == PromOne) begin
        mem_one[cur_addr_r] <= cur_data_r;
      end
    end
  end

  // table two: read from stage one data and table one read data, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (adv) begin
      rd2_r <= mem_two[a2];
      if (issue && cur_kind_r == KindLoad && cur_sel_r != PromOne) begin
        mem_two[cur_addr_r] <= cur_data_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = out_x_r;
  assign out_pixel_y    = out_y_r;
  assign out_last_pixel = out_last_r;
  assign out_red        = variant_r[1] ? colour[2] : colour[0];
  assign out_green      = colour[1];
  assign out_blue       = variant_r[1] ? colour[0] : colour[2];

endmodule
